/* rtl/slcc_pkg.sv */
// ----------------------------------------------------------------------------
// slcc_pkg
// shared types, codes and constants of the serial lamp command controller
// ----------------------------------------------------------------------------
`default_nettype none

package slcc_pkg;

   // field widths
   localparam int unsigned DUTY_W     = 17;
   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned STEPS_W    = 17;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned EVENT_W    = 2;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 17;

   // build-time defaults
   localparam int unsigned LINE_CHARS_DEF  = 31;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0]  REG_BLINK_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_PWM_STEPS      = 1'd1;
   localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd250;
   localparam logic [STEPS_W-1:0]    PWM_STEPS_RST      = 17'd4000;
   localparam logic [STEPS_W-1:0]    PWM_STEPS_MAX      = 17'h10000;

   // item kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // rear lamp modes
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

   // result events
   localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
   localparam logic [EVENT_W-1:0] EV_DUTY   = 2'd1;
   localparam logic [EVENT_W-1:0] EV_REAR   = 2'd2;
   localparam logic [EVENT_W-1:0] EV_REJECT = 2'd3;

   // pct * steps fits in 23 bits; floor(x/100) = (x * RECIP_100) >> 30 for that range
   localparam int unsigned           SCALED_W    = 23;
   localparam int unsigned           RECIP_W     = 24;
   localparam logic [RECIP_W-1:0]    RECIP_100   = 24'd10737419;
   localparam int unsigned           RECIP_SHIFT = 30;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_DUTY,
      CMD_REAR,
      CMD_REJECT
   } cmd_kind_type;

   // one classified item on its way from front to back
   typedef struct packed {
      cmd_kind_type          kind;
      logic [SCALED_W-1:0]   scaled;
      logic [MODE_W-1:0]     rear_mode;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic [DUTY_W-1:0]  duty_compare;
      logic               rear_pin;
      logic [MODE_W-1:0]  rear_mode;
      logic [EVENT_W-1:0] event_res;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/serial_lamp_command_controller_core.sv */
// ----------------------------------------------------------------------------
// serial_lamp_command_controller_core
// serial line command parser driving a front pwm lamp and a rear blink lamp
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   req      | in        | push / full            | func, rx_byte
//   rsp      | out       | empty / pop            | duty_compare, rear_pin,
//            |           |                        | rear_mode, event_res
//   csr      | in        | valid / ready (always) | index, wdata
//
// - one request beat per cycle sustained while full stays low; each beat gives exactly one result beat
// - a result beat passes through both queues: the command queue takes its request
//   beat at the accepting edge, and the back end writes the result queue at the
//   edge where it takes that command, once the result queue has room
// - the back end carries a 23x24 reciprocal multiply that turns pct*steps into
//   the compare value combinationally
// - synchronous reset empties both queues and restores the lamp and csr values
// - a stalled rsp side fills the result queue, then the command queue, then
//   raises full; each side stalls without losing a beat
// ----------------------------------------------------------------------------
`default_nettype none

module serial_lamp_command_controller_core #(
   parameter int unsigned LINE_CHARS  = slcc_pkg::LINE_CHARS_DEF,
   parameter int unsigned QUEUE_DEPTH = slcc_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request beats
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_func,
   input  wire logic [slcc_pkg::BYTE_W-1:0]     req_rx_byte,
   // result beats
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [slcc_pkg::DUTY_W-1:0]          rsp_duty_compare,
   output logic                                 rsp_rear_pin,
   output logic [slcc_pkg::MODE_W-1:0]          rsp_rear_mode,
   output logic [slcc_pkg::EVENT_W-1:0]         rsp_event_res,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [slcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [slcc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import slcc_pkg::*;

   logic [INTERVAL_W-1:0] blink_interval_ff;
   logic [STEPS_W-1:0]    pwm_steps_ff;

   logic    req_accept;
   cmd_type front_cmd;
   cmd_type queued_cmd;
   logic    cmd_empty;
   logic    rsp_q_full;
   logic    back_take;
   rsp_type back_rsp;
   rsp_type rsp_head;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_interval_ff <= BLINK_INTERVAL_RST;
         pwm_steps_ff      <= PWM_STEPS_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_BLINK_INTERVAL) begin
            blink_interval_ff <= csr_wdata[INTERVAL_W-1:0];
         end else if (csr_index == REG_PWM_STEPS) begin
            pwm_steps_ff <= csr_wdata[STEPS_W-1:0];
         end
      end
   end

   assign req_accept = req_push && !req_full;

   // front: line assembly and parse
   slcc_front #(
      .LINE_CHARS (LINE_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .func      (req_func),
      .rx_byte   (req_rx_byte),
      .pwm_steps (pwm_steps_ff),
      .cmd       (front_cmd)
   );

   // command queue between front and back
   slcc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_accept),
      .din   (front_cmd),
      .full  (req_full),
      .pop   (back_take),
      .dout  (queued_cmd),
      .empty (cmd_empty)
   );

   // back runs whenever a command waits and the result queue has room
   assign back_take = !cmd_empty && !rsp_q_full;

   slcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .take           (back_take),
      .cmd            (queued_cmd),
      .blink_interval (blink_interval_ff),
      .rsp            (back_rsp)
   );

   // result queue toward the rsp ports
   slcc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (back_take),
      .din   (back_rsp),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .dout  (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_duty_compare = rsp_head.duty_compare;
   assign rsp_rear_pin     = rsp_head.rear_pin;
   assign rsp_rear_mode    = rsp_head.rear_mode;
   assign rsp_event_res    = rsp_head.event_res;

endmodule

`default_nettype wire

/* rtl/slcc_fifo.sv */
// ----------------------------------------------------------------------------
// slcc_fifo
// small flop-based queue with first-word fall-through
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

/* rtl/slcc_front.sv */
// ----------------------------------------------------------------------------
// slcc_front
// line assembly and command parsing, one byte or tick per beat
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_front #(
   parameter int unsigned LINE_CHARS = slcc_pkg::LINE_CHARS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         func,
   input  wire logic [slcc_pkg::BYTE_W-1:0]  rx_byte,
   input  wire logic [slcc_pkg::STEPS_W-1:0] pwm_steps,
   output slcc_pkg::cmd_type                 cmd
);

   import slcc_pkg::*;

   localparam int unsigned CW = $clog2(LINE_CHARS + 1);

   localparam logic [1:0] LETTER_NONE = 2'd0;
   localparam logic [1:0] LETTER_L    = 2'd1;
   localparam logic [1:0] LETTER_R    = 2'd2;
   localparam logic [1:0] LETTER_BAD  = 2'd3;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
   localparam logic [BYTE_W-1:0] CH_R     = 8'h52;

   localparam logic [35:0] ACCUM_SAT = 36'h0_8000_0000;

   typedef enum logic [2:0] {
      PH_START,
      PH_TOKEN1,
      PH_GAP,
      PH_NUM_START,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_ERROR
   } phase_type;

   logic [CW-1:0] count_ff, count_in;
   phase_type     phase_ff, phase_in;
   logic [1:0]    letter_ff, letter_in;
   logic [31:0]   accum_ff, accum_in;
   logic          neg_ff, neg_in;
   logic          digit_ff, digit_in;
   logic          ended_ff, ended_in;

   logic          is_space, is_digit, is_blank, is_sign;
   logic [35:0]   accum_x10;
   logic [31:0]   accum_digit;
   logic          line_ok;
   logic [6:0]    pct;
   logic [STEPS_W-1:0] steps_clamped;
   logic [23:0]   scaled_full;
   logic [7:0]    low_byte;
   logic [MODE_W-1:0] rear_value;

   assign is_space = (rx_byte == CH_SPACE);
   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_blank = (rx_byte == CH_TAB) || (rx_byte == CH_VT) || (rx_byte == CH_FF);
   assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);

   // accum * 10 + digit, saturating at 2^31
   always_comb begin
      accum_x10 = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                + {32'd0, rx_byte[3:0] - CH_ZERO[3:0]};
      accum_digit = (accum_x10 > ACCUM_SAT) ? ACCUM_SAT[31:0] : accum_x10[31:0];
   end

   // line end: percent scaled by steps, and rear mode from low byte
   always_comb begin
      line_ok = ((phase_ff == PH_NUM_START) || (phase_ff == PH_SIGN) ||
                 (phase_ff == PH_DIGITS) || (phase_ff == PH_TRAIL)) && digit_ff &&
                ((letter_ff == LETTER_L) || (letter_ff == LETTER_R));
      pct = neg_ff ? 7'd0 : ((accum_ff > 32'd100) ? 7'd100 : accum_ff[6:0]);
      steps_clamped = (pwm_steps > PWM_STEPS_MAX) ? PWM_STEPS_MAX : pwm_steps;
      scaled_full = {17'd0, pct} * {7'd0, steps_clamped};
      if (neg_ff) begin
         low_byte = 8'd0 - accum_ff[7:0];
      end else begin
         low_byte = accum_ff[31] ? 8'hFF : accum_ff[7:0];
      end
      rear_value = (low_byte > 8'd2) ? MODE_BLINK : low_byte[1:0];
   end

   always_comb begin
      count_in  = count_ff;
      phase_in  = phase_ff;
      letter_in = letter_ff;
      accum_in  = accum_ff;
      neg_in    = neg_ff;
      digit_in  = digit_ff;
      ended_in  = ended_ff;
      cmd.kind      = CMD_NONE;
      cmd.scaled    = scaled_full[SCALED_W-1:0];
      cmd.rear_mode = rear_value;

      if (func == FUNC_TICK) begin
         cmd.kind = CMD_TICK;
      end else if (rx_byte == CH_LF) begin
         if (line_ok && (letter_ff == LETTER_L)) begin
            cmd.kind = CMD_DUTY;
         end else if (line_ok) begin
            cmd.kind = CMD_REAR;
         end else begin
            cmd.kind = CMD_REJECT;
         end
         count_in  = '0;
         phase_in  = PH_START;
         letter_in = LETTER_NONE;
         accum_in  = '0;
         neg_in    = 1'b0;
         digit_in  = 1'b0;
         ended_in  = 1'b0;
      end else if (rx_byte != CH_CR) begin
         if (count_ff < CW'(LINE_CHARS)) begin
            count_in = count_ff + 1'b1;
            if (rx_byte == CH_NUL) begin
               ended_in = 1'b1;
            end else if (!ended_ff) begin
               unique case (phase_ff)
                  PH_START: begin
                     if (!is_space) begin
                        letter_in = (rx_byte == CH_L) ? LETTER_L :
                                    (rx_byte == CH_R) ? LETTER_R : LETTER_BAD;
                        phase_in  = PH_TOKEN1;
                     end
                  end
                  PH_TOKEN1: begin
                     if (is_space) begin
                        phase_in = PH_GAP;
                     end else begin
                        letter_in = LETTER_BAD;
                     end
                  end
                  PH_GAP, PH_NUM_START: begin
                     // a non-space in the gap starts the number token
                     if (is_space) begin
                        phase_in = (phase_ff == PH_GAP) ? PH_GAP : PH_TRAIL;
                     end else if (is_blank) begin
                        phase_in = PH_NUM_START;
                     end else if (is_sign) begin
                        neg_in   = (rx_byte == CH_MINUS);
                        phase_in = PH_SIGN;
                     end else if (is_digit) begin
                        accum_in = accum_digit;
                        digit_in = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  PH_SIGN, PH_DIGITS: begin
                     if (is_space) begin
                        phase_in = PH_TRAIL;
                     end else if (is_digit) begin
                        accum_in = accum_digit;
                        digit_in = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  PH_TRAIL: begin
                     if (!is_space) begin
                        phase_in = PH_ERROR;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end else begin
            // overflow: drop the character, restart the line
            count_in  = '0;
            phase_in  = PH_START;
            letter_in = LETTER_NONE;
            accum_in  = '0;
            neg_in    = 1'b0;
            digit_in  = 1'b0;
            ended_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         phase_ff  <= PH_START;
         letter_ff <= LETTER_NONE;
         accum_ff  <= '0;
         neg_ff    <= 1'b0;
         digit_ff  <= 1'b0;
         ended_ff  <= 1'b0;
      end else if (accept) begin
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         letter_ff <= letter_in;
         accum_ff  <= accum_in;
         neg_ff    <= neg_in;
         digit_ff  <= digit_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/slcc_back.sv */
// ----------------------------------------------------------------------------
// slcc_back
// applies commands to the lamp state and forms one result per command
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            take,
   input  wire slcc_pkg::cmd_type               cmd,
   input  wire logic [slcc_pkg::INTERVAL_W-1:0] blink_interval,
   output slcc_pkg::rsp_type                    rsp
);

   import slcc_pkg::*;

   localparam int unsigned PROD_W = SCALED_W + RECIP_W;

   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic                  pin_ff, pin_in;
   logic                  phase_ff, phase_in;
   logic [INTERVAL_W-1:0] ticks_ff, ticks_in;

   logic [PROD_W-1:0]     prod;
   logic [DUTY_W-1:0]     quotient;
   logic [INTERVAL_W-1:0] interval_eff;
   logic [EVENT_W-1:0]    event_code;

   // divide by 100 through the reciprocal
   assign prod     = {{RECIP_W{1'b0}}, cmd.scaled} * {{SCALED_W{1'b0}}, RECIP_100};
   assign quotient = prod[RECIP_SHIFT +: DUTY_W];
   assign interval_eff = (blink_interval == '0) ? INTERVAL_W'(1) : blink_interval;

   always_comb begin
      duty_in    = duty_ff;
      mode_in    = mode_ff;
      pin_in     = pin_ff;
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      event_code = EV_NONE;

      unique case (cmd.kind)
         CMD_TICK: begin
            if (ticks_ff != '1) begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         CMD_DUTY: begin
            duty_in    = quotient;
            event_code = EV_DUTY;
         end
         CMD_REAR: begin
            mode_in    = cmd.rear_mode;
            event_code = EV_REAR;
            if (cmd.rear_mode == MODE_OFF) begin
               pin_in = 1'b0;
            end else if (cmd.rear_mode == MODE_ON) begin
               pin_in = 1'b1;
            end
         end
         CMD_REJECT: begin
            event_code = EV_REJECT;
         end
         default: begin
            event_code = EV_NONE;
         end
      endcase

      if ((mode_in == MODE_BLINK) && (ticks_in >= interval_eff)) begin
         phase_in = !phase_ff;
         pin_in   = !phase_ff;
         ticks_in = '0;
      end
   end

   assign rsp.duty_compare = duty_in;
   assign rsp.rear_pin     = pin_in;
   assign rsp.rear_mode    = mode_in;
   assign rsp.event_res    = event_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff  <= '0;
         mode_ff  <= MODE_ON;
         pin_ff   <= 1'b1;
         phase_ff <= 1'b0;
         ticks_ff <= '0;
      end else if (take) begin
         duty_ff  <= duty_in;
         mode_ff  <= mode_in;
         pin_ff   <= pin_in;
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/slcc_checker.sv */
// ----------------------------------------------------------------------------
// slcc_checker
// port-level checks of the serial lamp command controller
// ----------------------------------------------------------------------------
`default_nettype none

module slcc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_full,
   input wire logic                            rsp_empty,
   input wire logic                            rsp_pop,
   input wire logic [slcc_pkg::DUTY_W-1:0]     rsp_duty_compare,
   input wire logic                            rsp_rear_pin,
   input wire logic [slcc_pkg::MODE_W-1:0]     rsp_rear_mode,
   input wire logic [slcc_pkg::EVENT_W-1:0]    rsp_event_res
);

   import slcc_pkg::*;

   // reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // fixed modes drive the pin directly
   a_pin_follows_mode: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_rear_mode == MODE_OFF || rsp_rear_mode == MODE_ON)
      |-> rsp_rear_pin == rsp_rear_mode[0])
      else $error("rear pin does not match fixed mode");

   // compare value never exceeds the clamped pwm period, and the rear mode is a defined mode
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_duty_compare <= PWM_STEPS_MAX && rsp_rear_mode <= MODE_BLINK)
      else $error("result field out of range");

   // a waiting result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_duty_compare)
         && $stable(rsp_event_res) && $stable(rsp_rear_pin))
      else $error("waiting result changed");

endmodule

bind serial_lamp_command_controller_core slcc_checker u_slcc_checker (.*);

`default_nettype wire

/* verif/slcc_lamp_checker.sv */
// ----------------------------------------------------------------------------
// slcc_lamp_checker
// watches the request, result and register channels of the lamp controller,
// keeps its own copy of the line parser and lamp state, and compares every
// result beat field by field with the oldest predicted beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcc_lamp_checker
   import slcc_pkg::*;
#(
   parameter int unsigned LINE_CHARS = LINE_CHARS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   input  wire logic                  req_full,
   input  wire logic                  req_func,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   input  wire logic                  rsp_empty,
   input  wire logic                  rsp_pop,
   input  wire logic [DUTY_W-1:0]     rsp_duty_compare,
   input  wire logic                  rsp_rear_pin,
   input  wire logic [MODE_W-1:0]     rsp_rear_mode,
   input  wire logic [EVENT_W-1:0]    rsp_event_res,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         backlog,
   output int                         beats_in,
   output int                         beats_out,
   output int                         duty_lines,
   output int                         rear_lines,
   output int                         rejected_lines
);

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
   localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
   localparam logic [BYTE_W-1:0] CH_R     = 8'h52;

   localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
   localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
   localparam int unsigned PERCENT_TOP = 100;
   localparam int          REPORT_CAP  = 100;

   typedef enum logic [2:0] {
      SCAN_LEAD,
      SCAN_WORD,
      SCAN_GAP,
      SCAN_NUM_START,
      SCAN_SIGN,
      SCAN_DIGITS,
      SCAN_TRAIL,
      SCAN_BAD
   } scan_state_type;

   typedef enum logic [1:0] {
      LETTER_NONE,
      LETTER_L,
      LETTER_R,
      LETTER_OTHER
   } letter_type;

   // line parser state
   logic [7:0]           line_len;
   scan_state_type       scan;
   letter_type           letter;
   logic [31:0]          magnitude;
   logic                 negative;
   logic                 have_digit;
   logic                 text_done;
   // lamp state
   logic [DUTY_W-1:0]    duty;
   logic [MODE_W-1:0]    mode;
   logic                 pin;
   logic                 blink_phase;
   logic [15:0]          tick_count;
   // registers
   logic [INTERVAL_W-1:0] interval_reg;
   logic [STEPS_W-1:0]    steps_reg;

   rsp_type lamp_forecast[$];
   rsp_type predicted;
   rsp_type oldest;

   function automatic void clear_line();
      line_len   = '0;
      scan       = SCAN_LEAD;
      letter     = LETTER_NONE;
      magnitude  = '0;
      negative   = 1'b0;
      have_digit = 1'b0;
      text_done  = 1'b0;
   endfunction

   function automatic void take_digit(input logic [3:0] d);
      logic [63:0] t;
      t = 64'(magnitude) * 64'd10 + 64'(d);
      magnitude  = (t > 64'(MAG_LIMIT)) ? MAG_LIMIT : t[31:0];
      have_digit = 1'b1;
      scan       = SCAN_DIGITS;
   endfunction

   function automatic void scan_char(input logic [BYTE_W-1:0] c);
      logic sp, dig, blank;
      sp    = (c == CH_SPACE);
      dig   = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
      case (scan)
         SCAN_LEAD: begin
            if (!sp) begin
               letter = (c == CH_L) ? LETTER_L : (c == CH_R) ? LETTER_R : LETTER_OTHER;
               scan   = SCAN_WORD;
            end
         end
         SCAN_WORD: begin
            if (sp) scan = SCAN_GAP;
            else letter = LETTER_OTHER;
         end
         // a non-space after the gap is handled as the start of the number
         SCAN_GAP, SCAN_NUM_START: begin
            if (sp) begin
               if (scan == SCAN_NUM_START) scan = SCAN_TRAIL;
            end else if (blank) begin
               scan = SCAN_NUM_START;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               negative = (c == CH_MINUS);
               scan     = SCAN_SIGN;
            end else if (dig) begin
               take_digit(4'(c - CH_ZERO));
            end else begin
               scan = SCAN_BAD;
            end
         end
         SCAN_SIGN, SCAN_DIGITS: begin
            if (sp) scan = SCAN_TRAIL;
            else if (dig) take_digit(4'(c - CH_ZERO));
            else scan = SCAN_BAD;
         end
         SCAN_TRAIL: begin
            if (!sp) scan = SCAN_BAD;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [EVENT_W-1:0] finish_line();
      logic [EVENT_W-1:0] ev;
      logic               ok;
      int unsigned        pct;
      int unsigned        steps_eff;
      logic [31:0]        v;
      ev = EV_REJECT;
      ok = (scan inside {SCAN_NUM_START, SCAN_SIGN, SCAN_DIGITS, SCAN_TRAIL}) && have_digit &&
           (letter == LETTER_L || letter == LETTER_R);
      if (ok && letter == LETTER_L) begin
         pct       = negative ? 0 : ((magnitude > PERCENT_TOP) ? PERCENT_TOP : magnitude);
         steps_eff = (steps_reg > PWM_STEPS_MAX) ? PWM_STEPS_MAX : steps_reg;
         duty      = DUTY_W'((pct * steps_eff) / PERCENT_TOP);
         ev        = EV_DUTY;
         duty_lines++;
      end else if (ok) begin
         if (negative) v = 32'd0 - magnitude;
         else v = (magnitude > INT_MAX) ? INT_MAX : magnitude;
         v = v & 32'hFF;
         if (v > 32'(MODE_BLINK)) v = 32'(MODE_BLINK);
         mode = v[MODE_W-1:0];
         if (mode == MODE_OFF) pin = 1'b0;
         else if (mode == MODE_ON) pin = 1'b1;
         ev = EV_REAR;
         rear_lines++;
      end else begin
         rejected_lines++;
      end
      clear_line();
      return ev;
   endfunction

   function automatic rsp_type advance_lamp(input logic func, input logic [BYTE_W-1:0] c);
      rsp_type              r;
      logic [EVENT_W-1:0]   ev;
      logic [INTERVAL_W-1:0] iv;
      ev = EV_NONE;
      if (func == FUNC_TICK) begin
         if (tick_count != 16'hFFFF) tick_count++;
      end else if (c == CH_LF) begin
         ev = finish_line();
      end else if (c != CH_CR) begin
         if (line_len < LINE_CHARS) begin
            line_len++;
            if (c == CH_NUL) text_done = 1'b1;
            else if (!text_done) scan_char(c);
         end else begin
            clear_line();
         end
      end
      iv = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
      if (mode == MODE_BLINK && tick_count >= iv) begin
         blink_phase = ~blink_phase;
         pin         = blink_phase;
         tick_count  = '0;
      end
      r.duty_compare = duty;
      r.rear_pin     = pin;
      r.rear_mode    = mode;
      r.event_res    = ev;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < REPORT_CAP) $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         duty         = '0;
         mode         = MODE_ON;
         pin          = 1'b1;
         blink_phase  = 1'b0;
         tick_count   = '0;
         interval_reg = BLINK_INTERVAL_RST;
         steps_reg    = PWM_STEPS_RST;
         lamp_forecast.delete();
         mismatches     = 0;
         beats_in       = 0;
         beats_out      = 0;
         duty_lines     = 0;
         rear_lines     = 0;
         rejected_lines = 0;
         backlog       <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_BLINK_INTERVAL) interval_reg = csr_wdata[INTERVAL_W-1:0];
            else if (csr_index == REG_PWM_STEPS) steps_reg = csr_wdata[STEPS_W-1:0];
         end
         if (req_push && !req_full) begin
            predicted = advance_lamp(req_func, req_rx_byte);
            lamp_forecast.push_back(predicted);
            beats_in++;
         end
         if (rsp_pop && !rsp_empty) begin
            if (lamp_forecast.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with none expected", beats_out));
            end else begin
               oldest = lamp_forecast.pop_front();
               if (rsp_duty_compare !== oldest.duty_compare)
                  report_mismatch($sformatf("duty_compare on result beat %0d: expected %0d, got %0d",
                                            beats_out, oldest.duty_compare, rsp_duty_compare));
               if (rsp_rear_pin !== oldest.rear_pin)
                  report_mismatch($sformatf("rear_pin on result beat %0d: expected %0d, got %0d",
                                            beats_out, oldest.rear_pin, rsp_rear_pin));
               if (rsp_rear_mode !== oldest.rear_mode)
                  report_mismatch($sformatf("rear_mode on result beat %0d: expected %0d, got %0d",
                                            beats_out, oldest.rear_mode, rsp_rear_mode));
               if (rsp_event_res !== oldest.event_res)
                  report_mismatch($sformatf("event_res on result beat %0d: expected %0d, got %0d",
                                            beats_out, oldest.event_res, rsp_event_res));
            end
            beats_out++;
         end
         backlog <= lamp_forecast.size();
      end
   end

endmodule

/* verif/tb_serial_lamp_command_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_serial_lamp_command_controller_core
// drives command lines and millisecond ticks into the lamp controller under
// several register settings, with random idling on both queue sides, and
// leaves all prediction and comparison to the lamp checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_serial_lamp_command_controller_core;
   import slcc_pkg::*;

   localparam int          QUIET_LIMIT  = 1000;
   localparam int          PHASE_BEATS  = 155;
   localparam int          RANDOM_SETS  = 6;
   localparam int          IDLE_PCT     = 27;
   localparam logic [7:0]  NUL_BYTE     = 8'h00;
   // rear mode values that land on and around the byte wrap and the clamp
   localparam int unsigned REAR_PICKS [11] = '{0, 1, 2, 3, 255, 256, 257, 258, 511, 512, 514};

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block ports, all at known values from time zero
   logic                  req_push    = 1'b0;
   logic                  req_full;
   logic                  req_func    = FUNC_BYTE;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   logic [DUTY_W-1:0]     rsp_duty_compare;
   logic                  rsp_rear_pin;
   logic [MODE_W-1:0]     rsp_rear_mode;
   logic [EVENT_W-1:0]    rsp_event_res;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index   = REG_BLINK_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // checker outputs
   int mismatches;
   int backlog;
   int beats_in;
   int beats_out;
   int duty_lines;
   int rear_lines;
   int rejected_lines;

   // stimulus bookkeeping
   logic       steady = 1'b0;   // no idling on either side while set
   int         items_sent = 0;
   int         settings_done = 0;
   int         quiet = 0;
   bit [7:0]   line_buf[$];

   serial_lamp_command_controller_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_duty_compare (rsp_duty_compare),
      .rsp_rear_pin     (rsp_rear_pin),
      .rsp_rear_mode    (rsp_rear_mode),
      .rsp_event_res    (rsp_event_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   slcc_lamp_checker u_lamp_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_duty_compare (rsp_duty_compare),
      .rsp_rear_pin     (rsp_rear_pin),
      .rsp_rear_mode    (rsp_rear_mode),
      .rsp_event_res    (rsp_event_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .backlog          (backlog),
      .beats_in         (beats_in),
      .beats_out        (beats_out),
      .duty_lines       (duty_lines),
      .rear_lines       (rear_lines),
      .rejected_lines   (rejected_lines)
   );

   // result side: pop with a probability of about 73 percent, and always while steady
   always @(posedge clock) begin
      rsp_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog: any accepted beat on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // one request beat; random idle cycles in front of it unless steady,
   // then hold push until full is seen low at an edge
   task automatic push_item(input logic func, input logic [BYTE_W-1:0] b);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
      req_push    <= 1'b1;
      req_func    <= func;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   // ticks carry a random byte, which the block must ignore
   task automatic push_ticks(input int n);
      repeat (n) push_item(FUNC_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(FUNC_BYTE, s[i]);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   // drop push and wait until every predicted beat has been popped,
   // so the block is idle before a register write
   task automatic settle();
      req_push <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   // both registers back to back; valid stays high across the two beats
   task automatic program_regs(input logic [CSR_DATA_W-1:0] interval_data,
                               input logic [CSR_DATA_W-1:0] steps_data);
      csr_valid <= 1'b1;
      csr_index <= REG_BLINK_INTERVAL;
      csr_wdata <= interval_data;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_PWM_STEPS;
      csr_wdata <= steps_data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // a command, mostly well formed, with random content: optional lead spaces (a long
   // run overflows the line), L or R, optional blank before an optional sign,
   // digits either from a useful value or a random run that may saturate
   task automatic build_command();
      logic is_rear;
      int   r;
      string blanks;
      blanks = "\t\v\f";
      if ($urandom_range(19) == 0) repeat ($urandom_range(20, 30)) add_text(" ");
      else repeat ($urandom_range(0, 1)) add_text(" ");
      is_rear = 1'($urandom_range(0, 1));
      add_text(is_rear ? "R" : "L");
      repeat ($urandom_range(1, 2)) add_text(" ");
      if ($urandom_range(9) == 0) line_buf.push_back(blanks[$urandom_range(0, 2)]);
      r = $urandom_range(0, 4);
      if (r == 0) add_text("+");
      else if (r == 1) add_text("-");
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 12)) line_buf.push_back("0" + 8'($urandom_range(0, 9)));
      end else if (is_rear) begin
         if ($urandom_range(1) == 0) add_text($sformatf("%0d", REAR_PICKS[$urandom_range(0, 10)]));
         else add_text($sformatf("%0d", $urandom_range(0, 600)));
      end else begin
         add_text($sformatf("%0d", $urandom_range(0, 130)));
      end
      // a third token now and then
      if ($urandom_range(19) == 0) add_text(" 7");
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) add_text(" ");
      if ($urandom_range(6) == 0) add_text("\r");
   endtask

   // one random line: mostly commands, some noise, some with a zero byte,
   // with tick runs falling between any two bytes
   task automatic random_line();
      int    kind;
      int    len;
      string pool;
      pool = "LRlr +-0123456789\t\r";
      line_buf.delete();
      kind = $urandom_range(99);
      if (kind < 70) begin
         build_command();
      end else if (kind < 85) begin
         len = $urandom_range(0, 40);
         repeat (len) begin
            if ($urandom_range(1) == 0) line_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            else line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         build_command();
         line_buf.insert($urandom_range(0, line_buf.size()), NUL_BYTE);
      end
      add_text("\n");
      foreach (line_buf[i]) begin
         if ($urandom_range(3) == 0) push_ticks($urandom_range(1, 4));
         push_item(FUNC_BYTE, line_buf[i]);
      end
   endtask

   initial begin
      int                    phase_goal;
      logic [CSR_DATA_W-1:0] interval_data;
      logic [CSR_DATA_W-1:0] steps_data;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines under the reset register values
      send_text("L 100\r\n");                 // full brightness, cr ignored
      push_item(FUNC_TICK, 8'hFF);            // tick with an all-ones byte
      send_text("R \t+2\n");                  // blank and plus before the number
      push_item(FUNC_BYTE, 8'hFF);            // junk first token
      send_text("\n\n");                      // rejected, then an empty line
      send_text("L 9");
      push_item(FUNC_BYTE, NUL_BYTE);         // zero byte ends the text
      send_text("x\n");
      settle();

      // ticks keep counting while the lamp is on; entering blink after more
      // ticks than the interval must toggle on the very line that selects it
      program_regs({1'b0, 16'd40}, 17'd100);
      send_text("R 1\n");
      push_ticks(45);
      send_text("R 2\n");
      push_ticks(3);
      send_text("L 100\n");
      settle();

      // random lines under several settings, extremes first
      for (int p = 0; p < RANDOM_SETS; p++) begin
         case (p)
            0: begin
               interval_data = 17'd1;
               steps_data    = 17'd1;
            end
            1: begin
               interval_data = {1'b1, 16'd3};
               steps_data    = PWM_STEPS_MAX;
            end
            2: begin
               // zero interval acts as one, oversize steps act as the max
               interval_data = {1'($urandom_range(0, 1)), 16'd0};
               steps_data    = 17'h1FFFF;
            end
            3: begin
               interval_data = 17'd2;
               steps_data    = 17'd0;
            end
            4: begin
               interval_data = 17'($urandom_range(1, 6));
               steps_data    = 17'($urandom_range(1, 65536));
            end
            default: begin
               interval_data = {1'($urandom_range(0, 1)), 16'($urandom_range(1, 10))};
               steps_data    = 17'($urandom);
            end
         endcase
         program_regs(interval_data, steps_data);
         // one long stretch with no idling on either side
         steady     <= (p == 3);
         phase_goal  = items_sent + PHASE_BEATS;
         while (items_sent < phase_goal) random_line();
         settle();
         steady <= 1'b0;
      end

      // let the pipeline run out before the verdict
      repeat (4) @(posedge clock);
      $display("run covered %0d request beats and %0d result beats over %0d register settings",
               beats_in, beats_out, settings_done);
      $display("finished lines: %0d brightness, %0d rear mode, %0d rejected",
               duty_lines, rear_lines, rejected_lines);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
